// File: sv/aaa_pkg.sv
// Shared types, constants and the character map of the area-average text renderer.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package aaa_pkg;

    localparam int unsigned MaxSrcWidth   = 1024;
    localparam int unsigned MaxSrcHeight  = 1024;
    localparam int unsigned MaxTextCols   = 256;
    localparam int unsigned CharCount     = 70;

    localparam int unsigned SrcW   = 11;
    localparam int unsigned TxtW   = 9;
    localparam int unsigned ColW   = 8;
    localparam int unsigned PosW   = 10;
    localparam int unsigned SumW   = 28;
    localparam int unsigned AreaW  = 21;
    localparam int unsigned AddrW  = 9;
    localparam int unsigned WgtW   = 20;

    localparam logic [7:0] CharNewline = 8'h0A;
    localparam logic [7:0] CharEnd     = 8'h00;

    typedef enum logic [1:0] {
        CFG_SRC_WIDTH  = 2'd0,
        CFG_SRC_HEIGHT = 2'd1,
        CFG_OUT_WIDTH  = 2'd2,
        CFG_OUT_HEIGHT = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_MUL,
        B_RD,
        B_WR,
        B_DIV,
        B_EMIT
    } back_state_t;

    // effective (clamped) frame geometry
    typedef struct packed {
        logic [SrcW-1:0] src_w;
        logic [SrcW-1:0] src_h;
        logic [TxtW-1:0] txt_w;
        logic [SrcW-1:0] txt_h;
    } geom_t;

    // one classified pixel
    typedef struct packed {
        logic [7:0]      pixel;
        logic            bank;
        logic [ColW-1:0] col;
        logic [TxtW-1:0] ox0;
        logic [TxtW-1:0] ox1;
        logic [SrcW-1:0] oy0;
        logic [SrcW-1:0] oy1;
        logic            char_en;
        logic            nl;
        logic            fe;
    } item_t;

    localparam logic [7:0] CharMap [CharCount] = '{
        8'h24, 8'h40, 8'h42, 8'h25, 8'h38, 8'h26, 8'h57, 8'h4D, 8'h23, 8'h2A,
        8'h6F, 8'h61, 8'h68, 8'h6B, 8'h62, 8'h64, 8'h70, 8'h71, 8'h77, 8'h6D,
        8'h5A, 8'h4F, 8'h30, 8'h51, 8'h4C, 8'h43, 8'h4A, 8'h55, 8'h59, 8'h58,
        8'h7A, 8'h63, 8'h76, 8'h75, 8'h6E, 8'h78, 8'h72, 8'h6A, 8'h66, 8'h74,
        8'h2F, 8'h5C, 8'h7C, 8'h28, 8'h29, 8'h31, 8'h7B, 8'h7D, 8'h5B, 8'h5D,
        8'h3F, 8'h2D, 8'h5F, 8'h2B, 8'h7E, 8'h3C, 8'h3E, 8'h69, 8'h21, 8'h6C,
        8'h49, 8'h3B, 8'h3A, 8'h2C, 8'h22, 8'h5E, 8'h60, 8'h27, 8'h2E, 8'h20
    };

    // map an 8-bit cell average to its character
    function automatic logic [7:0] char_of(input logic [7:0] avg);
        logic [14:0] prod;
        logic [6:0]  idx;
        prod = 15'(avg) * 15'(CharCount);
        idx  = prod[14:8];
        if (idx > 7'(CharCount - 1))
        begin
            idx = 7'(CharCount - 1);
        end
        return CharMap[idx];
    endfunction

endpackage
`default_nettype wire

// File: sv/aaa_queue.sv
// Two-entry queue of classified pixels between the front and back parts.
// Depends on aaa_pkg for item_t.
`default_nettype none
module aaa_queue
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           flush,
    input  wire logic           push,
    input  wire aaa_pkg::item_t push_item,
    input  wire logic           pop,
    output logic                full,
    output logic                not_empty,
    output aaa_pkg::item_t      head
);
    import aaa_pkg::*;

    item_t      slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
        if (flush)
        begin
            wr_ptr_next = 1'b0;
            rd_ptr_next = 1'b0;
            count_next  = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// File: sv/aaa_front.sv
// Front part: takes pixels, tracks source position and cell overlaps by stepping remainders.
// Depends on aaa_pkg for geom_t and item_t.
`default_nettype none
module aaa_front
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            restart,
    input  wire aaa_pkg::geom_t  geom,
    input  wire logic            take,
    input  wire logic [7:0]      pixel,
    output aaa_pkg::item_t       item
);
    import aaa_pkg::*;

    logic [PosW-1:0] x_reg, x_next;
    logic [PosW-1:0] y_reg, y_next;
    logic [SrcW-1:0] rx_reg, rx_next;
    logic [SrcW-1:0] ry_reg, ry_next;
    logic [ColW-1:0] c0_reg, c0_next;
    logic            bank_reg, bank_next;

    logic [SrcW-1:0] w_ext;
    logic [SrcW-1:0] x_left;
    logic [SrcW-1:0] y_left;
    logic [SrcW-1:0] rx_sum;
    logic [SrcW-1:0] ry_sum;
    logic            last_col;
    logic            last_row;
    logic            col_end;
    logic            row_end;

    always_comb
    begin
        w_ext    = SrcW'(geom.txt_w);
        x_left   = geom.src_w - rx_reg;
        y_left   = geom.src_h - ry_reg;
        rx_sum   = rx_reg + w_ext;
        ry_sum   = ry_reg + geom.txt_h;
        col_end  = (rx_sum >= geom.src_w);
        row_end  = (ry_sum >= geom.src_h);
        last_col = ({1'b0, x_reg} == geom.src_w - 11'd1);
        last_row = ({1'b0, y_reg} == geom.src_h - 11'd1);

        item.pixel   = pixel;
        item.bank    = bank_reg;
        item.col     = c0_reg;
        item.ox0     = (w_ext < x_left) ? geom.txt_w : x_left[TxtW-1:0];
        item.ox1     = geom.txt_w - item.ox0;
        item.oy0     = (geom.txt_h < y_left) ? geom.txt_h : y_left;
        item.oy1     = geom.txt_h - item.oy0;
        item.char_en = row_end && col_end;
        item.nl      = row_end && last_col;
        item.fe      = last_row && last_col;

        x_next    = x_reg;
        y_next    = y_reg;
        rx_next   = rx_reg;
        ry_next   = ry_reg;
        c0_next   = c0_reg;
        bank_next = bank_reg;
        if (take)
        begin
            if (last_col)
            begin
                // wrap to the next source row
                x_next  = '0;
                rx_next = '0;
                c0_next = '0;
                y_next  = y_reg + 10'd1;
                ry_next = row_end ? (ry_sum - geom.src_h) : ry_sum;
                if (row_end)
                begin
                    bank_next = ~bank_reg;
                end
                if (last_row)
                begin
                    y_next    = '0;
                    ry_next   = '0;
                    bank_next = 1'b0;
                end
            end
            else
            begin
                x_next  = x_reg + 10'd1;
                rx_next = col_end ? (rx_sum - geom.src_w) : rx_sum;
                c0_next = col_end ? (c0_reg + 8'd1) : c0_reg;
            end
        end
        if (restart)
        begin
            x_next    = '0;
            y_next    = '0;
            rx_next   = '0;
            ry_next   = '0;
            c0_next   = '0;
            bank_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            y_reg    <= '0;
            rx_reg   <= '0;
            ry_reg   <= '0;
            c0_reg   <= '0;
            bank_reg <= 1'b0;
        end
        else
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
            c0_reg   <= c0_next;
            bank_reg <= bank_next;
        end
    end

endmodule
`default_nettype wire

// File: sv/aaa_back.sv
// Back part: weighted column-sum updates in a two-bank memory, cell divide and result output.
// Depends on aaa_pkg for types, constants and the character map.
`default_nettype none
module aaa_back
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            restart,
    input  wire aaa_pkg::geom_t  geom,
    input  wire logic            q_valid,
    input  wire aaa_pkg::item_t  q_item,
    output logic                 q_pop,
    output logic                 clearing,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [7:0]           out_code,
    output logic                 out_done,
    output logic                 out_last
);
    import aaa_pkg::*;

    logic [SumW-1:0] mem [2*MaxTextCols];

    back_state_t     state_reg, state_next;
    logic [AddrW:0]  clr_reg, clr_next;
    item_t           item_reg, item_next;
    logic [1:0]      op_reg, op_next;
    logic [WgtW-1:0] oxy_reg, oxy_next;
    logic [SumW-1:0] add_reg, add_next;
    logic [SumW-1:0] rd_data_reg;
    logic [SumW-1:0] rem_reg, rem_next;
    logic [SumW-1:0] den_reg, den_next;
    logic [7:0]      quo_reg, quo_next;
    logic [2:0]      bit_reg, bit_next;
    logic [2:0]      pend_reg, pend_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_code_reg, out_code_next;
    logic            out_done_reg, out_done_next;
    logic            out_last_reg, out_last_next;
    logic [AreaW-1:0] area_reg;

    logic             mem_we;
    logic [AddrW-1:0] mem_waddr;
    logic [SumW-1:0]  mem_wdata;
    logic [AddrW-1:0] mem_raddr;

    logic [3:0]      op_en;
    logic            col_plus;
    logic            use_b;
    logic [TxtW-1:0] ox_sel;
    logic [SrcW-1:0] oy_sel;
    logic [AddrW-1:0] op_addr;
    logic [SumW-1:0] sum_new;
    logic [1:0]      op_after;
    logic [1:0]      op_first;
    logic [3:0]      q_en;
    logic            slot_free;

    assign clearing  = (state_reg == B_CLEAR);
    assign out_valid = out_valid_reg;
    assign out_code  = out_code_reg;
    assign out_done  = out_done_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        // update order: right neighbour, next-row cell, next-row neighbour, own cell last
        op_en    = {1'b1, (item_reg.ox1 != '0) && (item_reg.oy1 != '0),
                    (item_reg.oy1 != '0), (item_reg.ox1 != '0)};
        q_en     = {1'b1, (q_item.ox1 != '0) && (q_item.oy1 != '0),
                    (q_item.oy1 != '0), (q_item.ox1 != '0)};
        col_plus = (op_reg == 2'd0) || (op_reg == 2'd2);
        use_b    = (op_reg == 2'd1) || (op_reg == 2'd2);
        ox_sel   = col_plus ? item_reg.ox1 : item_reg.ox0;
        oy_sel   = use_b ? item_reg.oy1 : item_reg.oy0;
        op_addr  = {item_reg.bank ^ use_b, item_reg.col + ColW'(col_plus)};
        sum_new  = rd_data_reg + add_reg;

        op_after = 2'd3;
        for (int i = 2; i >= 0; i--)
        begin
            if ((2'(i) > op_reg) && op_en[i])
            begin
                op_after = 2'(i);
            end
        end
        op_first = 2'd3;
        for (int i = 2; i >= 0; i--)
        begin
            if (q_en[i])
            begin
                op_first = 2'(i);
            end
        end
        slot_free = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        item_next      = item_reg;
        op_next        = op_reg;
        oxy_next       = oxy_reg;
        add_next       = add_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        quo_next       = quo_reg;
        bit_next       = bit_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_code_next  = out_code_reg;
        out_done_next  = out_done_reg;
        out_last_next  = out_last_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = op_addr;
        mem_wdata      = sum_new;
        mem_raddr      = op_addr;

        unique case (state_reg)
            B_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg[AddrW-1:0];
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == (AddrW+1)'(2*MaxTextCols - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    op_next    = op_first;
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                oxy_next   = WgtW'(ox_sel) * WgtW'(oy_sel);
                state_next = B_RD;
            end
            B_RD:
            begin
                add_next   = SumW'(item_reg.pixel) * SumW'(oxy_reg);
                state_next = B_WR;
            end
            B_WR:
            begin
                mem_we = 1'b1;
                if (op_reg == 2'd3)
                begin
                    pend_next = {item_reg.fe, item_reg.nl, item_reg.char_en};
                    if (item_reg.char_en)
                    begin
                        // cell complete: take the sum and zero the slot
                        mem_wdata  = '0;
                        rem_next   = sum_new;
                        den_next   = {area_reg, 7'b0};
                        quo_next   = '0;
                        bit_next   = '0;
                        state_next = B_DIV;
                    end
                    else
                    begin
                        state_next = B_EMIT;
                    end
                end
                else
                begin
                    op_next    = op_after;
                    state_next = B_MUL;
                end
            end
            B_DIV:
            begin
                if (rem_reg >= den_reg)
                begin
                    rem_next = rem_reg - den_reg;
                    quo_next = {quo_reg[6:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_reg[6:0], 1'b0};
                end
                den_next = den_reg >> 1;
                bit_next = bit_reg + 3'd1;
                if (bit_reg == 3'd7)
                begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (pend_reg == '0)
                begin
                    state_next = B_IDLE;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    priority if (pend_reg[0])
                    begin
                        out_code_next = char_of(quo_reg);
                        out_done_next = 1'b0;
                        pend_next     = {pend_reg[2:1], 1'b0};
                    end
                    else if (pend_reg[1])
                    begin
                        out_code_next = CharNewline;
                        out_done_next = 1'b0;
                        pend_next     = {pend_reg[2], 2'b0};
                    end
                    else
                    begin
                        out_code_next = CharEnd;
                        out_done_next = 1'b1;
                        pend_next     = '0;
                    end
                    out_last_next = (pend_next == '0);
                    if (pend_next == '0)
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_CLEAR;
            end
        endcase

        if (restart)
        begin
            state_next = B_CLEAR;
            clr_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        op_reg       <= op_next;
        oxy_reg      <= oxy_next;
        add_reg      <= add_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        quo_reg      <= quo_next;
        bit_reg      <= bit_next;
        out_code_reg <= out_code_next;
        out_done_reg <= out_done_next;
        out_last_reg <= out_last_next;
        area_reg     <= AreaW'(geom.src_w * geom.src_h);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

endmodule
`default_nettype wire

// File: sv/area_average_ascii_art_core.sv
// Top level of the area-average text renderer: configuration registers, clamping, wiring.
// Depends on aaa_pkg, aaa_front, aaa_queue and aaa_back.
//
//  channel    | direction | transfer content
//  -----------+-----------+--------------------------------------------------
//  s_axis     | in        | tdata[7:0] pixel, one gray source pixel, raster order
//  m_axis     | out       | tdata[7:0] char_code, tuser frame_done, tlast last_of_item
//  cfg        | in        | cfg_index register number, cfg_data value (always ready)
//
// In the back part each pixel is popped, then takes one to four column-sum
// read-modify-writes (states B_MUL, B_RD and B_WR each; one read and one write port),
// an 8-bit restoring divide when a cell completes, then one result per cycle
// while the receiver is ready, or a single B_EMIT pass when the pixel gives none.
// Most work: a completed cell with four updates; a frame-end pixel has a single update.
// The front part classifies a pixel in its accept cycle; two queue entries sit between.
// After reset and after every configuration write the 512-entry sum memory is
// cleared; s_axis_tready stays low meanwhile.
// A full result register holds the back part without losing work.
`default_nettype none
module area_average_ascii_art_core
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] pixel
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] char_code
    output logic             m_axis_tuser,   // [0] frame_done
    output logic             m_axis_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data
);
    import aaa_pkg::*;

    logic [SrcW-1:0] src_w_reg, src_w_next;
    logic [SrcW-1:0] src_h_reg, src_h_next;
    logic [TxtW-1:0] out_w_reg, out_w_next;
    logic [SrcW-1:0] out_h_reg, out_h_next;

    logic            cfg_we;
    geom_t           geom;
    logic [SrcW-1:0] w_cap;
    item_t           front_item;
    item_t           q_head;
    logic            q_full;
    logic            q_not_empty;
    logic            q_pop;
    logic            clearing;
    logic            take;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // hold register values; any write restarts the frame
    always_comb
    begin
        src_w_next = src_w_reg;
        src_h_next = src_h_reg;
        out_w_next = out_w_reg;
        out_h_next = out_h_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SRC_WIDTH:  src_w_next = cfg_data;
                CFG_SRC_HEIGHT: src_h_next = cfg_data;
                CFG_OUT_WIDTH:  out_w_next = cfg_data[TxtW-1:0];
                CFG_OUT_HEIGHT: out_h_next = cfg_data;
                default:        src_w_next = src_w_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= SrcW'(1024);
            src_h_reg <= SrcW'(1024);
            out_w_reg <= TxtW'(128);
            out_h_reg <= SrcW'(64);
        end
        else
        begin
            src_w_reg <= src_w_next;
            src_h_reg <= src_h_next;
            out_w_reg <= out_w_next;
            out_h_reg <= out_h_next;
        end
    end

    // clamp: sources to 1..max, text grid to 1..source size, width also to MaxTextCols (downscale only)
    always_comb
    begin
        geom.src_w = (src_w_reg == '0) ? SrcW'(1)
                   : (src_w_reg > SrcW'(MaxSrcWidth)) ? SrcW'(MaxSrcWidth) : src_w_reg;
        geom.src_h = (src_h_reg == '0) ? SrcW'(1)
                   : (src_h_reg > SrcW'(MaxSrcHeight)) ? SrcW'(MaxSrcHeight) : src_h_reg;
        w_cap      = (geom.src_w < SrcW'(MaxTextCols)) ? geom.src_w : SrcW'(MaxTextCols);
        geom.txt_w = (out_w_reg == '0) ? TxtW'(1)
                   : (SrcW'(out_w_reg) > w_cap) ? w_cap[TxtW-1:0] : out_w_reg;
        geom.txt_h = (out_h_reg == '0) ? SrcW'(1)
                   : (out_h_reg > geom.src_h) ? geom.src_h : out_h_reg;
    end

    assign s_axis_tready = !q_full && !clearing;
    assign take          = s_axis_tvalid && s_axis_tready;

    aaa_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (cfg_we),
        .geom    (geom),
        .take    (take),
        .pixel   (s_axis_tdata),
        .item    (front_item)
    );

    aaa_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .flush     (cfg_we),
        .push      (take),
        .push_item (front_item),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    aaa_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (cfg_we),
        .geom      (geom),
        .q_valid   (q_not_empty),
        .q_item    (q_head),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_code  (m_axis_tdata),
        .out_done  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule
`default_nettype wire

// File: tb/aaa_text_checker.sv
// Checker for the area-average text renderer: watches the configuration, pixel
// and character channels, predicts every character and compares. Depends on aaa_pkg.
`timescale 1ns / 100ps
module aaa_text_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [7:0]  m_axis_tdata,
    input  wire logic        m_axis_tuser,
    input  wire logic        m_axis_tlast,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [10:0] cfg_data,
    output int               fail_count,
    output int               chars_pending
);
    import aaa_pkg::*;

    typedef struct {
        logic [7:0] code;
        logic       done;
        logic       last;
    } text_char_t;

    text_char_t        expected_chars[$];
    logic [SrcW-1:0]   reg_src_w;
    logic [SrcW-1:0]   reg_src_h;
    logic [TxtW-1:0]   reg_txt_w;
    logic [SrcW-1:0]   reg_txt_h;
    longint unsigned   cell_sums[2*MaxTextCols];
    longint unsigned   pos_x;
    longint unsigned   pos_y;
    logic              row_bank;

    function automatic longint unsigned clamp_dim(longint unsigned v, longint unsigned hi);
        if (v < 1)
        begin
            return 1;
        end
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [7:0] glyph_of(longint unsigned avg);
        longint unsigned idx;
        idx = (avg * CharCount) >> 8;
        if (idx > CharCount - 1)
        begin
            idx = CharCount - 1;
        end
        return CharMap[idx];
    endfunction

    task automatic restart_frame();
        foreach (cell_sums[i])
        begin
            cell_sums[i] = 0;
        end
        pos_x    = 0;
        pos_y    = 0;
        row_bank = 1'b0;
    endtask

    task automatic push_char(logic [7:0] code, logic done);
        text_char_t c;
        c.code = code;
        c.done = done;
        c.last = 1'b0;
        expected_chars.push_back(c);
    endtask

    // advance the frame by one pixel and queue the characters it completes
    task automatic predict_pixel(longint unsigned p);
        longint unsigned big_w, big_h, w, h, x, y, ux, uy, c0, r0, e;
        longint unsigned ox0, ox1, oy0, oy1, a, b;
        bit              col_end, row_end;
        int              first;
        big_w = clamp_dim(reg_src_w, MaxSrcWidth);
        big_h = clamp_dim(reg_src_h, MaxSrcHeight);
        w = clamp_dim(reg_txt_w, (big_w < MaxTextCols) ? big_w : MaxTextCols);
        h = clamp_dim(reg_txt_h, big_h);
        first = expected_chars.size();
        if (pos_x >= big_w || pos_y >= big_h)
        begin
            restart_frame();
        end
        x = pos_x;
        y = pos_y;
        a = row_bank;
        b = a ^ 1;
        ux  = x * w;
        c0  = ux / big_w;
        e   = (c0 + 1) * big_w;
        ox0 = ((ux + w < e) ? ux + w : e) - ux;
        ox1 = w - ox0;
        uy  = y * h;
        r0  = uy / big_h;
        e   = (r0 + 1) * big_h;
        oy0 = ((uy + h < e) ? uy + h : e) - uy;
        oy1 = h - oy0;
        if (c0 >= w)
        begin
            c0 = w - 1;
        end
        cell_sums[a*MaxTextCols + c0] += p * ox0 * oy0;
        if (ox1 != 0 && c0 + 1 < w)
        begin
            cell_sums[a*MaxTextCols + c0 + 1] += p * ox1 * oy0;
        end
        if (oy1 != 0)
        begin
            cell_sums[b*MaxTextCols + c0] += p * ox0 * oy1;
            if (ox1 != 0 && c0 + 1 < w)
            begin
                cell_sums[b*MaxTextCols + c0 + 1] += p * ox1 * oy1;
            end
        end
        col_end = (((c0 + 1) * big_w - 1) / w) == x;
        row_end = (((r0 + 1) * big_h - 1) / h) == y;
        if (row_end && col_end)
        begin
            push_char(glyph_of(cell_sums[a*MaxTextCols + c0] / (big_w * big_h)), 1'b0);
            cell_sums[a*MaxTextCols + c0] = 0;
        end
        if (row_end && x == big_w - 1)
        begin
            push_char(CharNewline, 1'b0);
            row_bank = b[0];
        end
        x++;
        if (x >= big_w)
        begin
            x = 0;
            y++;
        end
        if (y >= big_h)
        begin
            push_char(CharEnd, 1'b1);
            restart_frame();
        end
        else
        begin
            pos_x = x;
            pos_y = y;
        end
        if (expected_chars.size() > first)
        begin
            expected_chars[$].last = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        text_char_t want;
        if (!rst_n)
        begin
            reg_src_w  = SrcW'(MaxSrcWidth);
            reg_src_h  = SrcW'(MaxSrcHeight);
            reg_txt_w  = TxtW'(128);
            reg_txt_h  = SrcW'(64);
            fail_count = 0;
            expected_chars.delete();
            restart_frame();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_chars.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("unexpected character transfer %h", m_axis_tdata);
                    end
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (m_axis_tdata !== want.code || m_axis_tuser !== want.done
                        || m_axis_tlast !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("char mismatch: expected %h/%b/%b, got %h/%b/%b",
                                     want.code, want.done, want.last,
                                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_SRC_WIDTH:  reg_src_w = cfg_data;
                    CFG_SRC_HEIGHT: reg_src_h = cfg_data;
                    CFG_OUT_WIDTH:  reg_txt_w = cfg_data[TxtW-1:0];
                    CFG_OUT_HEIGHT: reg_txt_h = cfg_data;
                    default: ;
                endcase
                restart_frame();
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_pixel(s_axis_tdata);
            end
        end
        chars_pending = expected_chars.size();
    end

endmodule

// File: tb/testbench.sv
// Top of the text renderer testbench: clock, reset, pixel and configuration
// stimulus, receiver back-pressure and the verdict. Depends on aaa_pkg,
// aaa_text_checker and area_average_ascii_art_core.
`timescale 1ns / 100ps
module testbench;
    import aaa_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [10:0] cfg_data = '0;
    int          fail_count;
    int          chars_pending;

    // shared control between the pixel sender and the character receiver
    bit          quiet_run = 1'b0;   // no idling at all in the closing part
    bit          long_hold = 1'b0;   // ask the receiver for one long hold-off
    int          pixels_sent = 0;

    always #2 clk = ~clk;

    area_average_ascii_art_core uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [7:0] pixel
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [7:0] char_code
        .m_axis_tuser  (m_axis_tuser),    // [0] frame_done
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    aaa_text_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .chars_pending (chars_pending)
    );

    // Receiver: bursts of ready and of stall, one long hold-off on request.
    // The hold-off is counted here so the sender keeps offering pixels and
    // the block fills up and drops s_axis_tready.
    initial
    begin
        int  n;
        bit  hold_taken;
        hold_taken = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold && !hold_taken)
            begin
                hold_taken = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (quiet_run || $urandom_range(0, 3) != 0)
            begin
                m_axis_tready <= 1'b1;
                n = $urandom_range(1, 12);
                repeat (n - 1) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b0;
                n = $urandom_range(1, 7);
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    // drop valid at times, then offer the pixel and hold it; call only from the falling edge
    task automatic send_pixel(logic [7:0] p);
        int n;
        if (!quiet_run && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            n = $urandom_range(1, 7);
            repeat (n) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        pixels_sent++;
        @(negedge clk);
    endtask

    // let the block drain, then sit out its per-pixel latency
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (chars_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (64) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [10:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_geometry(logic [10:0] sw, logic [10:0] sh,
                                logic [10:0] tw, logic [10:0] th);
        drain();
        write_reg(CFG_SRC_WIDTH, sw);
        write_reg(CFG_SRC_HEIGHT, sh);
        write_reg(CFG_OUT_WIDTH, tw);
        write_reg(CFG_OUT_HEIGHT, th);
    endtask

    initial
    begin
        int sw, sh, tw, th, count;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset geometry: big frame, no characters yet
        send_pixel(8'h00);
        send_pixel(8'hFF);
        // one-pixel frame: every pixel gives glyph, newline and frame end
        set_geometry(11'd1, 11'd1, 11'd1, 11'd1);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h80);
        // zero registers clamp up to one
        set_geometry(11'd0, 11'd0, 11'd0, 11'd0);
        send_pixel(8'h55);
        send_pixel(8'hAA);
        // fractional overlaps: 3x2 source onto 2x2 text
        set_geometry(11'd3, 11'd2, 11'd2, 11'd2);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h01);
        send_pixel(8'hFE);
        send_pixel(8'h7F);
        // oversized registers clamp down; glyph every four pixels
        set_geometry(11'h7FF, 11'd1, 11'h1FF, 11'h7FF);
        repeat (12) send_pixel(8'($urandom));
        // text size above source size clamps to the source
        set_geometry(11'd2, 11'd3, 11'd9, 11'd9);
        repeat (6) send_pixel(8'($urandom));

        // long receiver hold-off: every pixel gives three results, so the
        // block fills up and stalls its input while pixels keep coming
        set_geometry(11'd1, 11'd1, 11'd1, 11'd1);
        long_hold = 1'b1;
        repeat (16) send_pixel(8'($urandom));

        // random frames, mostly complete, some cut short by a new geometry
        while (pixels_sent < 70)
        begin
            sw = $urandom_range(1, 10);
            sh = $urandom_range(1, 6);
            tw = $urandom_range(0, sw + 2);
            th = $urandom_range(0, sh + 2);
            if ($urandom_range(0, 7) == 0)
            begin
                sw = 0;
            end
            set_geometry(11'(sw), 11'(sh), 11'(tw), 11'(th));
            if (sw == 0)
            begin
                sw = 1;
            end
            count = sw * sh * $urandom_range(1, 2);
            if ($urandom_range(0, 4) == 0)
            begin
                count = $urandom_range(1, sw * sh);
            end
            repeat (count) send_pixel(8'($urandom));
        end

        // closing part without idling
        quiet_run = 1'b1;
        set_geometry(11'd4, 11'd4, 11'd2, 11'd2);
        repeat (32) send_pixel(8'($urandom));
        drain();

        if (fail_count == 0 && chars_pending == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial
    begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: area_average_ascii_art_core.f
sv/aaa_pkg.sv
sv/aaa_queue.sv
sv/aaa_front.sv
sv/aaa_back.sv
sv/area_average_ascii_art_core.sv
tb/aaa_text_checker.sv
tb/testbench.sv
